/* design/msclim_pkg.sv */
// Shared types, codes and the magnitude band clamp for the motor speed command limiter.
// Depends on nothing; every other design file imports it.
`default_nettype none

package msclim_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_STEP = 2'd1,
      STATUS_FAULT    = 2'd2
   } status_type;

   // Command codes carried by each transaction.
   typedef enum logic {
      CMD_SET_SPEED = 1'b0,
      CMD_SET_ACCEL = 1'b1
   } command_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_SPEED_FLOOR   = 3'd0,
      REG_SPEED_CEILING = 3'd1,
      REG_ACCEL_FLOOR   = 3'd2,
      REG_ACCEL_CEILING = 3'd3,
      REG_CURRENT_LIMIT = 3'd4
   } reg_index_type;

   localparam int unsigned MagWidth     = 31;
   localparam int unsigned LimitWidth   = 15;
   localparam int unsigned IndexWidth   = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [MagWidth-1:0]   MagMax   = '1;
   localparam logic [LimitWidth-1:0] LimitMax = '1;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [MagWidth-1:0]   speed_floor;
      logic [MagWidth-1:0]   speed_ceiling;
      logic [MagWidth-1:0]   accel_floor;
      logic [MagWidth-1:0]   accel_ceiling;
      logic [LimitWidth-1:0] current_limit;
   } cfg_type;

   // Zero passes; otherwise a magnitude below the floor is raised to it, else one above
   // the ceiling is lowered to it, and the sign is kept.
   function automatic logic signed [31:0] band_clamp(
      input logic signed [31:0] value,
      input logic [MagWidth-1:0] lo,
      input logic [MagWidth-1:0] hi
   );
      logic [31:0] mag;
      logic [31:0] lo_ext;
      logic [31:0] hi_ext;
      logic [31:0] result;
      mag    = value[31] ? (~value + 32'd1) : value;
      lo_ext = {1'b0, lo};
      hi_ext = {1'b0, hi};
      if (value == 32'sd0) begin
         result = 32'd0;
      end else if (mag < lo_ext) begin
         result = value[31] ? (~lo_ext + 32'd1) : lo_ext;
      end else if (mag > hi_ext) begin
         result = value[31] ? (~hi_ext + 32'd1) : hi_ext;
      end else begin
         result = value;
      end
      return $signed(result);
   endfunction

endpackage

`default_nettype wire

/* design/msclim_csr.sv */
// Configuration register file of the motor speed command limiter.
// Depends on msclim_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module msclim_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [msclim_pkg::IndexWidth-1:0]    csr_index,
   input  wire logic [msclim_pkg::CsrDataWidth-1:0]  csr_data,
   output msclim_pkg::cfg_type                       cfg
);
   import msclim_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the index; unknown indexes leave every register alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_SPEED_FLOOR:   cfg_in.speed_floor   = csr_data[MagWidth-1:0];
            REG_SPEED_CEILING: cfg_in.speed_ceiling = csr_data[MagWidth-1:0];
            REG_ACCEL_FLOOR:   cfg_in.accel_floor   = csr_data[MagWidth-1:0];
            REG_ACCEL_CEILING: cfg_in.accel_ceiling = csr_data[MagWidth-1:0];
            REG_CURRENT_LIMIT: cfg_in.current_limit = csr_data[LimitWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_floor   <= '0;
         cfg_ff.speed_ceiling <= MagMax;
         cfg_ff.accel_floor   <= '0;
         cfg_ff.accel_ceiling <= MagMax;
         cfg_ff.current_limit <= LimitMax;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/msclim_update.sv */
// Speed update logic: acceleration times time step, saturating add and speed clamp.
// Depends on msclim_pkg for band_clamp, command codes and cfg_type.
`default_nettype none

module msclim_update (
   input  wire logic                          command,
   input  wire logic signed [31:0]            clamped_ref,
   input  wire logic [15:0]                   time_step,
   input  wire logic signed [31:0]            held_speed,
   input  wire msclim_pkg::cfg_type           cfg,
   output logic signed [31:0]                 next_speed
);
   import msclim_pkg::*;

   logic signed [48:0] product;
   logic signed [32:0] delta;
   logic signed [33:0] sum;
   logic signed [31:0] saturated;

   // Q16.16 times Q0.16; an arithmetic shift floors back to Q16.16.
   assign product = clamped_ref * $signed({1'b0, time_step});
   assign delta   = product[48:16];
   assign sum     = {{2{held_speed[31]}}, held_speed} + {delta[32], delta};

   // Saturate the sum to the signed 32-bit range.
   always_comb begin
      if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
         saturated = sum[31:0];
      end else if (sum[33]) begin
         saturated = {1'b1, 31'd0};
      end else begin
         saturated = {1'b0, {31{1'b1}}};
      end
   end

   // Speed mode already carries the clamped speed.
   always_comb begin
      unique case (command_type'(command))
         CMD_SET_SPEED: next_speed = clamped_ref;
         CMD_SET_ACCEL: next_speed = band_clamp(saturated, cfg.speed_floor,
                                                cfg.speed_ceiling);
         default:       next_speed = clamped_ref;
      endcase
   end

endmodule

`default_nettype wire

/* design/motor_speed_command_limiter.sv */
// Top level of the motor speed command limiter: handshakes, pipeline and held state.
// Depends on msclim_pkg, msclim_csr and msclim_update.
//
//   Channel  Handshake              Payload                                          Dir
//   req      req_valid, req_stall   req_command, req_reference_value, req_time_step,  in
//                                   req_measured_current
//   rsp      rsp_valid, rsp_stall   rsp_status, rsp_motor_speed, rsp_stored_current   out
//   csr      csr_valid, csr_ready   csr_index, csr_data                               in
//
// One transaction is accepted per cycle while req_stall is low; it is registered in the input
// register, and its result then in the result register, from which it can be taken.
// Ahead of the input register the reference is clamped and time step and current are
// checked; after it the multiply, saturating add and speed clamp use the held speed.
// Reset is synchronous: registers return to their reset values, held speed and current
// to zero. A stalled result holds; the input register still fills and then stalls req.
`default_nettype none

module motor_speed_command_limiter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_command,
   input  wire logic signed [31:0]                   req_reference_value,
   input  wire logic [15:0]                          req_time_step,
   input  wire logic signed [15:0]                   req_measured_current,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_status,
   output logic signed [31:0]                        rsp_motor_speed,
   output logic signed [15:0]                        rsp_stored_current,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [msclim_pkg::IndexWidth-1:0]    csr_index,
   input  wire logic [msclim_pkg::CsrDataWidth-1:0]  csr_data
);
   import msclim_pkg::*;

   cfg_type cfg;

   logic               s1_valid_ff;
   status_type         s1_status_ff;
   logic               s1_command_ff;
   logic signed [31:0] s1_clamped_ff;
   logic [15:0]        s1_time_step_ff;
   logic signed [15:0] s1_current_ff;

   status_type         s1_status_in;
   logic [MagWidth-1:0] lo_bound;
   logic [MagWidth-1:0] hi_bound;
   logic signed [31:0] s1_clamped_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic signed [31:0] rsp_speed_ff;
   logic signed [15:0] rsp_current_ff;

   logic signed [31:0] held_speed_ff;
   logic signed [15:0] held_current_ff;

   logic               out_ready;
   logic               s1_move;
   logic               s1_take;
   logic               s1_ok;
   logic signed [31:0] next_speed;

   msclim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake control for the two stages.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign s1_take   = req_valid && !req_stall;
   assign s1_ok     = (s1_status_ff == STATUS_OK);

   // Ingress checks: a zero time step wins over an overcurrent.
   always_comb begin
      priority if (req_time_step == 16'd0) begin
         s1_status_in = STATUS_BAD_STEP;
      end else if (req_measured_current > $signed({1'b0, cfg.current_limit})) begin
         s1_status_in = STATUS_FAULT;
      end else begin
         s1_status_in = STATUS_OK;
      end
   end

   // Clamp the reference into the band that its command selects.
   assign lo_bound = (req_command == CMD_SET_ACCEL) ? cfg.accel_floor : cfg.speed_floor;
   assign hi_bound = (req_command == CMD_SET_ACCEL) ? cfg.accel_ceiling : cfg.speed_ceiling;
   assign s1_clamped_in = band_clamp(req_reference_value, lo_bound, hi_bound);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_status_ff    <= s1_status_in;
         s1_command_ff   <= req_command;
         s1_clamped_ff   <= s1_clamped_in;
         s1_time_step_ff <= req_time_step;
         s1_current_ff   <= req_measured_current;
      end
   end

   msclim_update u_update (
      .command     (s1_command_ff),
      .clamped_ref (s1_clamped_ff),
      .time_step   (s1_time_step_ff),
      .held_speed  (held_speed_ff),
      .cfg         (cfg),
      .next_speed  (next_speed)
   );

   // Held state changes only on a successful tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_speed_ff   <= '0;
         held_current_ff <= '0;
      end else if (s1_move && s1_ok) begin
         held_speed_ff   <= next_speed;
         held_current_ff <= s1_current_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_status_ff  <= s1_status_ff;
         rsp_speed_ff   <= s1_ok ? next_speed : held_speed_ff;
         rsp_current_ff <= s1_ok ? s1_current_ff : held_current_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_motor_speed    = rsp_speed_ff;
   assign rsp_stored_current = rsp_current_ff;

   // A shown result always matches the held state it leaves behind.
   a_result_matches_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_speed_ff == held_speed_ff) && (rsp_current_ff == held_current_ff))
      else $error("result differs from held state");

   // The input side only stalls when the ingress stage is occupied.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty ingress stage");

   // A blocked pipeline keeps both of its transactions.
   a_no_loss_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |=> s1_valid_ff && rsp_valid_ff)
      else $error("transaction lost while stalled");

endmodule

`default_nettype wire

/* sim/motor_speed_command_limiter_tb.sv */
// Self-checking testbench for motor_speed_command_limiter: directed ticks, then random phases.
// Depends on msclim_pkg and the motor_speed_command_limiter RTL; needs nothing else.
`default_nettype none

module motor_speed_command_limiter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msclim_pkg::*;

   localparam int unsigned     QuietLimit      = 1000;
   localparam int unsigned     HoldOffCycles   = 90;
   localparam int unsigned     RandomPhases    = 8;
   localparam int unsigned     TicksPerPhase   = 53;
   localparam logic [2:0]      FirstSpareIndex = REG_CURRENT_LIMIT + 3'd1;
   localparam longint          SpeedTop        = 64'sd2147483647;
   localparam longint          SpeedBottom     = -64'sd2147483648;

   typedef struct {
      status_type         status;
      logic signed [31:0] speed;
      logic signed [15:0] current;
   } limiter_output_type;

   // Shadow of the limiter: register copies, held state and the outputs still due.
   class speed_scoreboard;
      logic [30:0]        speed_lo;
      logic [30:0]        speed_hi;
      logic [30:0]        accel_lo;
      logic [30:0]        accel_hi;
      logic [14:0]        trip_level;
      logic signed [31:0] held_speed;
      logic signed [15:0] held_current;
      limiter_output_type predicted_outputs[$];
      int unsigned        errors;
      int unsigned        outputs_seen;

      function new();
         speed_lo     = '0;
         speed_hi     = MagMax;
         accel_lo     = '0;
         accel_hi     = MagMax;
         trip_level   = LimitMax;
         held_speed   = '0;
         held_current = '0;
         errors       = 0;
         outputs_seen = 0;
      endfunction

      function int unsigned pending();
         return predicted_outputs.size();
      endfunction

      // Zero passes; a nonzero magnitude is raised to the floor, else lowered to the ceiling.
      function longint band_limit(longint value, longint lo, longint hi);
         longint mag;
         if (value == 0) return 0;
         mag = (value < 0) ? -value : value;
         if (mag < lo) return (value < 0) ? -lo : lo;
         if (mag > hi) return (value < 0) ? -hi : hi;
         return value;
      endfunction

      function void note_write(logic [2:0] index, logic [31:0] data);
         case (index)
            REG_SPEED_FLOOR:   speed_lo   = data[30:0];
            REG_SPEED_CEILING: speed_hi   = data[30:0];
            REG_ACCEL_FLOOR:   accel_lo   = data[30:0];
            REG_ACCEL_CEILING: accel_hi   = data[30:0];
            REG_CURRENT_LIMIT: trip_level = data[14:0];
            default: ;
         endcase
      endfunction

      // One control tick; failed ticks leave the held speed and current alone.
      function limiter_output_type predict_tick(command_type cmd, logic signed [31:0] demand,
                                                logic [15:0] dt, logic signed [15:0] cur);
         limiter_output_type result_v;
         longint             accel;
         longint             target;
         if (dt == 16'd0) begin
            result_v.status = STATUS_BAD_STEP;
         end else if (longint'(cur) > longint'(trip_level)) begin
            result_v.status = STATUS_FAULT;
         end else begin
            result_v.status = STATUS_OK;
            if (cmd == CMD_SET_SPEED) begin
               target = band_limit(longint'(demand), speed_lo, speed_hi);
            end else begin
               // Q16.16 times Q0.16 is exact in Q16.32; the arithmetic shift rounds down.
               accel  = band_limit(longint'(demand), accel_lo, accel_hi);
               target = longint'(held_speed) + ((accel * longint'(dt)) >>> 16);
               if (target > SpeedTop) target = SpeedTop;
               if (target < SpeedBottom) target = SpeedBottom;
               target = band_limit(target, speed_lo, speed_hi);
            end
            held_speed   = 32'(target);
            held_current = cur;
         end
         result_v.speed   = held_speed;
         result_v.current = held_current;
         return result_v;
      endfunction

      function void note_tick(command_type cmd, logic signed [31:0] demand,
                              logic [15:0] dt, logic signed [15:0] cur);
         predicted_outputs.push_back(predict_tick(cmd, demand, dt, cur));
      endfunction

      // Prints one line for the mismatch and counts it.
      task report_mismatch(input string what);
         errors++;
         $display("%t mismatch: %s", $realtime, what);
      endtask

      task check_result(input logic [1:0] status, input logic signed [31:0] speed,
                        input logic signed [15:0] current);
         limiter_output_type want;
         outputs_seen++;
         if (predicted_outputs.size() == 0) begin
            report_mismatch($sformatf("output %0d arrived with nothing outstanding",
                                      outputs_seen));
            return;
         end
         want = predicted_outputs.pop_front();
         if (status !== want.status || speed !== want.speed || current !== want.current)
            report_mismatch($sformatf(
               "output %0d: status %0d/%0d speed %h/%h current %h/%h (got/want)",
               outputs_seen, status, want.status, speed, want.speed, current, want.current));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = 1'b0;
   logic signed [31:0] req_reference_value = '0;
   logic [15:0]        req_time_step = '0;
   logic signed [15:0] req_measured_current = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_motor_speed;
   logic signed [15:0] rsp_stored_current;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   bit send_gaps_on  = 1'b1;
   bit recv_stalls_on = 1'b1;
   bit hold_off_due  = 1'b0;

   speed_scoreboard sb = new();

   always #6 clock = ~clock;

   motor_speed_command_limiter u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_reference_value  (req_reference_value),
      .req_time_step        (req_time_step),
      .req_measured_current (req_measured_current),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_motor_speed      (rsp_motor_speed),
      .rsp_stored_current   (rsp_stored_current),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // Every accepted transaction on the three channels goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.note_write(csr_index, csr_data);
         if (req_valid && !req_stall)
            sb.note_tick(command_type'(req_command), req_reference_value, req_time_step,
                         req_measured_current);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_motor_speed, rsp_stored_current);
      end
   end

   // Ends the run when no channel has moved a transaction for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("motor_speed_command_limiter_tb: errors");
      $finish;
   end

   // Result side: a random stall before each transaction while stalls are on, and one long hold-off on request.
   initial begin : result_sink
      int unsigned hold;
      forever begin
         hold = recv_stalls_on ? $urandom_range(0, 17) : 0;
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            hold = HoldOffCycles;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offers one tick, after a random gap when gaps are on, and returns at the edge that accepts it.
   task automatic send_tick(input command_type cmd, input logic signed [31:0] demand,
                            input logic [15:0] dt, input logic signed [15:0] cur);
      int unsigned gap;
      gap = send_gaps_on ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_command          <= cmd;
      req_reference_value  <= demand;
      req_time_step        <= dt;
      req_measured_current <= cur;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Unused upper data bits carry noise; the block must drop them.
   task automatic load_limits(input logic [30:0] s_lo, input logic [30:0] s_hi,
                              input logic [30:0] a_lo, input logic [30:0] a_hi,
                              input logic [14:0] trip);
      write_reg(REG_SPEED_FLOOR,   {1'($urandom()), s_lo});
      write_reg(REG_SPEED_CEILING, {1'($urandom()), s_hi});
      write_reg(REG_ACCEL_FLOOR,   {1'($urandom()), a_lo});
      write_reg(REG_ACCEL_CEILING, {1'($urandom()), a_hi});
      write_reg(REG_CURRENT_LIMIT, {17'($urandom()), trip});
      write_reg(FirstSpareIndex + 3'($urandom_range(0, 2)), $urandom());
   endtask

   // Waits until every predicted output has arrived, plus a margin.
   task automatic settle();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [30:0] draw_level(bit upper);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MagMax;
         2: return 31'($urandom());
         default: return upper ? 31'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF))
                               : 31'($urandom_range(0, 32'h0010_0000));
      endcase
   endfunction

   // Random tick: magnitudes spread over many scales, occasional bad steps and overcurrents.
   task automatic random_tick();
      command_type        cmd;
      logic signed [31:0] demand;
      logic [15:0]        dt;
      logic signed [15:0] cur;
      cmd = command_type'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: demand = 32'sh7FFF_FFFF;
         1: demand = 32'sh8000_0000;
         2: demand = '0;
         3, 4: demand = $urandom();
         default: demand = $signed($urandom()) >>> $urandom_range(0, 24);
      endcase
      case ($urandom_range(0, 19))
         0: dt = '0;
         1: dt = 16'hFFFF;
         2: dt = 16'd1;
         3, 4, 5, 6: dt = 16'($urandom_range(1, 65535));
         default: dt = 16'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 9))
         0: cur = 16'($urandom());
         1: cur = 16'sh8000;
         2: cur = 16'(sb.trip_level) + 16'sd1;
         default: cur = 16'($urandom_range(0, sb.trip_level));
      endcase
      send_tick(cmd, demand, dt, cur);
   endtask

   initial begin : stimulus
      logic [14:0] trip;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset limits: field extremes, saturation both ways, round-down of a tiny step.
      send_tick(CMD_SET_SPEED, 32'sh7FFF_FFFF, 16'd1,      16'sd0);
      send_tick(CMD_SET_SPEED, 32'sh8000_0000, 16'hFFFF,   16'sh7FFF);
      send_tick(CMD_SET_ACCEL, 32'sh7FFF_FFFF, 16'hFFFF,   16'sh8000);
      send_tick(CMD_SET_ACCEL, 32'sh7FFF_FFFF, 16'hFFFF,   16'sd12);
      send_tick(CMD_SET_ACCEL, 32'sh8000_0000, 16'hFFFF,   -16'sd5);
      send_tick(CMD_SET_ACCEL, 32'sh8000_0000, 16'hFFFF,   16'sd3);
      send_tick(CMD_SET_SPEED, 32'sd0,         16'd0,      16'sd9);
      send_tick(CMD_SET_SPEED, -32'sd1,        16'd1,      16'sd5);
      send_tick(CMD_SET_ACCEL, -32'sd1,        16'd1,      16'sd0);
      req_valid <= 1'b0;
      settle();

      // A narrow band: floor and ceiling clamps with sign kept, current trip edges.
      load_limits(31'h0003_0000, 31'h0064_0000, 31'h0001_0000, 31'h0032_0000, 15'd1000);
      send_tick(CMD_SET_SPEED, 32'sh0001_0000,  16'd100,  16'sd10);
      send_tick(CMD_SET_SPEED, -32'sh0001_0000, 16'd100,  16'sd10);
      send_tick(CMD_SET_SPEED, 32'sh00C8_0000,  16'd100,  16'sd10);
      send_tick(CMD_SET_SPEED, 32'sh8000_0000,  16'd100,  16'sd10);
      send_tick(CMD_SET_SPEED, 32'sd0,          16'd100,  16'sd10);
      send_tick(CMD_SET_SPEED, 32'sh0010_0000,  16'd100,  16'sd1001);
      send_tick(CMD_SET_SPEED, 32'sh0010_0000,  16'd100,  16'sd1000);
      send_tick(CMD_SET_SPEED, 32'sh0020_0000,  16'd0,    16'sd1001);
      send_tick(CMD_SET_ACCEL, 32'sh000A_0000,  16'h8000, 16'sd7);
      send_tick(CMD_SET_ACCEL, 32'sd1,          16'h4000, 16'sd7);
      send_tick(CMD_SET_ACCEL, -32'sh00C8_0000, 16'hFFFF, 16'sd7);
      req_valid <= 1'b0;
      settle();

      // Floor above ceiling, so the floor test decides; a zero current limit.
      load_limits(31'h00C8_0000, 31'h0064_0000, '0, MagMax, 15'd0);
      send_tick(CMD_SET_SPEED, 32'sh0005_0000,  16'd50, 16'sd0);
      send_tick(CMD_SET_SPEED, -32'sh0096_0000, 16'd50, 16'sd0);
      send_tick(CMD_SET_SPEED, 32'sh012C_0000,  16'd50, 16'sd1);
      send_tick(CMD_SET_ACCEL, 32'sd1,          16'd50, -16'sd1);
      req_valid <= 1'b0;

      // Random phases, each with its own limits and its own idle pattern.
      for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
         settle();
         if (phase == 0) begin
            load_limits('0, '0, '0, '0, '0);
         end else if (phase == 1) begin
            load_limits(MagMax, MagMax, MagMax, MagMax, LimitMax);
         end else begin
            trip = ($urandom_range(0, 3) == 0) ? 15'($urandom())
                                               : 15'($urandom_range(16000, 32767));
            load_limits(draw_level(1'b0), draw_level(1'b1), draw_level(1'b0),
                        draw_level(1'b1), trip);
         end
         send_gaps_on   = ($urandom_range(0, 2) != 0);
         recv_stalls_on = ($urandom_range(0, 2) != 0);
         if (phase == 3 || phase == 6) begin
            send_gaps_on = 1'b0;
            hold_off_due = 1'b1;
         end
         repeat (TicksPerPhase) random_tick();
         req_valid <= 1'b0;
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("motor_speed_command_limiter_tb: clean");
      else
         $display("motor_speed_command_limiter_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
